// ----- rtl/cpsa_pkg.sv -----
package cpsa_pkg;

    localparam int FWD_DEPTH = 4096;
    localparam int ADJ_DEPTH = 4096;
    localparam int RES_DEPTH = 4096;
    localparam int FWD_AW    = $clog2(FWD_DEPTH);
    localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int IDX_W     = 12;

    localparam logic [2:0] REQ_LOAD_FWD = 3'd0;
    localparam logic [2:0] REQ_LOAD_ADJ = 3'd1;
    localparam logic [2:0] REQ_CONTRIB  = 3'd2;
    localparam logic [2:0] REQ_READ     = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    // input item, req_type in the lowest bits of tdata (341 bits -> 344)
    localparam int IN_BITS  = 341;
    localparam int IN_BYTES = 344;
    localparam int OUT_BYTES = 72;

    typedef struct packed {
        logic [63:0] load_value;
        logic [31:0] acc_scale;
        logic [63:0] material_coef;
        logic [63:0] adjoint_coef;
        logic [31:0] weight_b;
        logic [31:0] weight_a;
        logic [1:0]  fwd_use;
        logic [11:0] fwd_index_b;
        logic [11:0] fwd_index_a;
        logic [11:0] adjoint_index;
        logic [11:0] target_index;
        logic [2:0]  req_type;
    } t_req;

    // round Q8.56 sum to Q4.28 with saturation
    function automatic logic signed [31:0] to_q428(input logic signed [65:0] x);
        logic signed [65:0] r;
        begin
            r = (x + 66'sd134217728) >>> 28;
            if (r > 66'sd2147483647)
                to_q428 = 32'sh7fffffff;
            else if (r < -66'sd2147483648)
                to_q428 = 32'sh80000000;
            else
                to_q428 = r[31:0];
        end
    endfunction

endpackage

// ----- rtl/cpsa_ram.sv -----
module cpsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/cpsa_datapath.sv -----
module cpsa_datapath
    import cpsa_pkg::*;
(
    input  logic               i_clk,
    input  t_req               i_req,
    input  logic [63:0]        i_fa,
    input  logic [63:0]        i_fb,
    input  logic [63:0]        i_adj,
    input  logic               i_use_a,
    input  logic               i_use_b,
    input  logic [3:0]         i_stage,
    output logic signed [63:0] o_term
);
    // at most one multiply level per stage, registered between
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_fre, r_fim, r_are, r_aim, r_mre, r_mim, r_pre;
    logic signed [31:0] wa, wb, ac_re, ac_im, mc_re, mc_im;

    assign wa    = i_use_a ? i_req.weight_a : '0;
    assign wb    = i_use_b ? i_req.weight_b : '0;
    assign ac_re = i_req.adjoint_coef[63:32];
    assign ac_im = i_req.adjoint_coef[31:0];
    assign mc_re = i_req.material_coef[63:32];
    assign mc_im = i_req.material_coef[31:0];

    always_ff @(posedge i_clk) begin
        case (i_stage)
            4'd1: begin
                r_p0 <= $signed(i_fa[63:32]) * wa;
                r_p1 <= $signed(i_fb[63:32]) * wb;
                r_p2 <= $signed(i_fa[31:0]) * wa;
                r_p3 <= $signed(i_fb[31:0]) * wb;
            end
            4'd2: begin
                r_fre <= to_q428(66'(r_p0) + 66'(r_p1));
                r_fim <= to_q428(66'(r_p2) + 66'(r_p3));
                r_p0 <= $signed(i_adj[63:32]) * ac_re;
                r_p1 <= $signed(i_adj[31:0]) * ac_im;
                r_p2 <= $signed(i_adj[63:32]) * ac_im;
                r_p3 <= $signed(i_adj[31:0]) * ac_re;
            end
            4'd3: begin
                r_are <= to_q428(66'(r_p0) - 66'(r_p1));
                r_aim <= to_q428(66'(r_p2) + 66'(r_p3));
                r_p0 <= r_fre * mc_re;
                r_p1 <= r_fim * mc_im;
                r_p2 <= r_fre * mc_im;
                r_p3 <= r_fim * mc_re;
            end
            4'd4: begin
                r_mre <= to_q428(66'(r_p0) - 66'(r_p1));
                r_mim <= to_q428(66'(r_p2) + 66'(r_p3));
            end
            4'd5: begin
                r_p0 <= r_are * r_mre;
                r_p1 <= r_aim * r_mim;
            end
            4'd6: begin
                r_pre <= to_q428(66'(r_p0) - 66'(r_p1));
            end
            4'd7: begin
                r_p2 <= r_pre * $signed(i_req.acc_scale);
            end
            default: begin
            end
        endcase
    end

    assign o_term = (r_p2 + 64'sd32768) >>> 16;
endmodule

// ----- rtl/complex_product_scatter_accumulate.sv -----
// channel   | dir | tdata fields (low bit up)                         | tuser
// s_axis    | in  | req_type..load_value, see t_req                    | none
// m_axis    | out | result_value[63:0], saturated[64]                  | none
// Loads and reserved codes finish on acceptance; reads pass S_RD and S_OUT, clears
// S_RD and S_WB; a contribution runs S_RD, the multiply chain (32x32 multiplies in
// S_CALC) and the result memory read-modify-write. One item is in flight at a time.
// Reset clears control and the saturation flag, then a clearing pass zeroes
// every entry of the result memory; no item is taken until it ends.
// A result waits in the output register; a stall on m_axis holds the block.
module complex_product_scatter_accumulate
    import cpsa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES-1:0]    s_axis_tdata,  // t_req fields, req_type lowest
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES-1:0]   m_axis_tdata   // result_value, saturated
);
    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CALC, S_WB, S_OUT} t_state;

    t_state r_state;
    t_req   r_req;
    logic [RES_AW:0] r_clr;
    logic [3:0]  r_stage;
    logic        r_sat, r_ua, r_ub, r_aok, r_tok, r_rdok;
    logic [63:0] r_res, r_bval;
    logic [63:0] fa, fb, adj, rres, rwdata;
    logic        fwe, awe, rwe;
    logic [RES_AW-1:0] rwaddr, rraddr;
    logic signed [63:0] term, acc, sum;
    logic        ovf;
    t_req        in_req;

    assign in_req = s_axis_tdata[IN_BITS-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    wire acc_in = s_axis_tvalid && s_axis_tready;

    wire load_fwd = acc_in && in_req.req_type == REQ_LOAD_FWD &&
                    in_req.target_index < IDX_W'(FWD_DEPTH - 1) + 1;
    wire load_adj = acc_in && in_req.req_type == REQ_LOAD_ADJ &&
                    in_req.target_index < IDX_W'(ADJ_DEPTH - 1) + 1;
    assign fwe = load_fwd;
    assign awe = load_adj;

    cpsa_ram #(.WIDTH(64), .DEPTH(FWD_DEPTH)) u_fwd_a (
        .i_clk, .i_we(fwe), .i_waddr(in_req.target_index[FWD_AW-1:0]),
        .i_wdata(in_req.load_value), .i_raddr(in_req.fwd_index_a[FWD_AW-1:0]),
        .o_rdata(fa));
    cpsa_ram #(.WIDTH(64), .DEPTH(FWD_DEPTH)) u_fwd_b (
        .i_clk, .i_we(fwe), .i_waddr(in_req.target_index[FWD_AW-1:0]),
        .i_wdata(in_req.load_value), .i_raddr(in_req.fwd_index_b[FWD_AW-1:0]),
        .o_rdata(fb));
    cpsa_ram #(.WIDTH(64), .DEPTH(ADJ_DEPTH)) u_adj (
        .i_clk, .i_we(awe), .i_waddr(in_req.target_index[ADJ_AW-1:0]),
        .i_wdata(in_req.load_value), .i_raddr(in_req.adjoint_index[ADJ_AW-1:0]),
        .o_rdata(adj));

    // forward/adjoint read data follows the input read address and is not held; capture into regs
    logic [63:0] r_fa, r_fb, r_adj;

    assign rraddr = in_req.target_index[RES_AW-1:0];
    assign rwe    = (r_state == S_CLR) || (r_state == S_WB);
    assign rwaddr = (r_state == S_CLR) ? r_clr[RES_AW-1:0] : r_req.target_index[RES_AW-1:0];
    assign rwdata = (r_state == S_CLR) ? '0 : r_bval;

    cpsa_ram #(.WIDTH(64), .DEPTH(RES_DEPTH)) u_res (
        .i_clk, .i_we(rwe), .i_waddr(rwaddr), .i_wdata(rwdata),
        .i_raddr(rraddr), .o_rdata(rres));

    cpsa_datapath u_dp (
        .i_clk, .i_req(r_req), .i_fa(r_fa), .i_fb(r_fb), .i_adj(r_adj),
        .i_use_a(r_ua), .i_use_b(r_ub), .i_stage(r_stage), .o_term(term));

    assign acc = r_res;
    assign sum = acc + term;
    assign ovf = (acc[63] == term[63]) && (sum[63] != acc[63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_sat   <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_stage <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (RES_AW+1)'(RES_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc_in) begin
                        r_req <= in_req;
                        r_ua  <= in_req.fwd_use[0] &&
                                 in_req.fwd_index_a < IDX_W'(FWD_DEPTH - 1) + 1;
                        r_ub  <= in_req.fwd_use[1] &&
                                 in_req.fwd_index_b < IDX_W'(FWD_DEPTH - 1) + 1;
                        r_aok <= in_req.adjoint_index < IDX_W'(ADJ_DEPTH - 1) + 1;
                        r_tok <= in_req.target_index < IDX_W'(RES_DEPTH - 1) + 1;
                        unique case (in_req.req_type) inside
                            REQ_CONTRIB, REQ_READ, REQ_CLEAR: r_state <= S_RD;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD: begin
                    r_fa  <= fa;
                    r_fb  <= fb;
                    r_adj <= r_aok ? adj : '0;
                    r_res <= rres;
                    r_stage <= 4'd1;
                    unique case (r_req.req_type)
                        REQ_READ: begin
                            m_axis_tdata <= {7'd0, r_sat, r_tok ? rres : 64'd0};
                            m_axis_tvalid <= 1'b1;
                            r_state <= S_OUT;
                        end
                        REQ_CLEAR: begin
                            r_bval <= '0;
                            r_state <= r_tok ? S_WB : S_IDLE;
                        end
                        default: r_state <= r_tok ? S_CALC : S_IDLE;
                    endcase
                end
                S_CALC: begin
                    r_stage <= r_stage + 1'b1;
                    if (r_stage == 4'd8) begin
                        if (ovf) r_sat <= 1'b1;
                        r_bval <= ovf ? (acc[63] ? 64'h8000000000000000
                                                 : 64'h7fffffffffffffff) : sum;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_IDLE;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/cpsa_checker.sv -----
module cpsa_checker
    import cpsa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_BYTES-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped under stall");
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |=> !m_axis_tvalid || m_axis_tdata[64])
        else $error("saturation flag cleared");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with result pending");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0)
        else $error("padding nonzero");
endmodule

bind complex_product_scatter_accumulate cpsa_checker u_chk (.*);
